/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, quiet while reset is held
`define BCF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication form
`define BCF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/bcf_pkg.sv */
package bcf_pkg;

  localparam int MAX_VERTICES = 8;
  localparam int VW           = 3;
  localparam int CW           = 4;
  localparam int DISC_W       = 4;
  localparam int EDGE_CAP     = (MAX_VERTICES * (MAX_VERTICES - 1)) / 2;
  localparam int EW           = $clog2(EDGE_CAP + 1);
  localparam int COMP_W       = 5;
  localparam logic [CW-1:0] VCOUNT_RST = CW'(MAX_VERTICES);

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_RUN   = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_ADD_WA, S_ADD_RB, S_ADD_WB, S_CLR, S_ROOT, S_ROW,
    S_SCAN, S_BACK, S_RET, S_POP, S_POP_D, S_FIN
  } state_t;

  typedef struct packed {
    logic [COMP_W-1:0] comp;
    logic [VW-1:0]     from_v;
    logic [VW-1:0]     to_v;
    logic              present;
    logic              eoc;
    logic              last;
  } res_t;

  typedef struct packed {
    logic vld;
    logic fin;
    res_t item;
  } emit_t;

  typedef struct packed {
    logic [VW-1:0]           u;
    logic [CW-1:0]           v;
    logic [DISC_W-1:0]       disc;
    logic [DISC_W-1:0]       low;
    logic [VW-1:0]           par;
    logic [MAX_VERTICES-1:0] row;
  } frame_t;

endpackage

/* rtl/bcf_if.sv */
interface bcf_in_if import bcf_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [1:0]    cmd;
  logic [VW-1:0] vertex_a;
  logic [VW-1:0] vertex_b;
  modport source(output valid, cmd, vertex_a, vertex_b, input ready);
  modport sink(input valid, cmd, vertex_a, vertex_b, output ready);
endinterface

interface bcf_out_if import bcf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COMP_W-1:0] component_index;
  logic [VW-1:0]     edge_from;
  logic [VW-1:0]     edge_to;
  logic              edge_present;
  logic              end_of_component;
  logic              last;
  modport source(output valid, component_index, edge_from, edge_to, edge_present,
                 end_of_component, last, input ready);
  modport sink(input valid, component_index, edge_from, edge_to, edge_present,
               end_of_component, last, output ready);
endinterface

/* rtl/bcf_ram.sv */
module bcf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/bcf_ctrl.sv */
`include "assert_macros.svh"

module bcf_ctrl import bcf_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [CW-1:0] vcount,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    in_cmd,
  input  logic [VW-1:0] in_a,
  input  logic [VW-1:0] in_b,
  output emit_t         emit,
  input  logic          emit_rdy
);

  localparam int ADJ_AW = $clog2(MAX_VERTICES);

  state_t state_r, state_nxt;

  logic [VW-1:0]           b_r, b_nxt, clr_r, clr_nxt;
  logic [VW-1:0]           u_r, u_nxt, up_r, up_nxt, bv_r, bv_nxt;
  logic [VW-1:0]           ta_r, ta_nxt, tb_r, tb_nxt;
  logic [CW-1:0]           v_r, v_nxt, root_r, root_nxt, depth_r, depth_nxt;
  logic [DISC_W-1:0]       ud_r, ud_nxt, ul_r, ul_nxt, time_r, time_nxt;
  logic [MAX_VERTICES-1:0] row_r, row_nxt, vis_r, vis_nxt;
  logic [EW-1:0]           esc_r, esc_nxt;
  logic [COMP_W-1:0]       comp_r, comp_nxt;
  frame_t                  fs_r [MAX_VERTICES];
  logic                    fs_we;
  logic [VW-1:0]           fs_wa;
  frame_t                  fs_wd, fpop;

  logic                    adj_we;
  logic [ADJ_AW-1:0]       adj_wa, adj_ra;
  logic [MAX_VERTICES-1:0] adj_wd, adj_rd;
  logic                    disc_we;
  logic [VW-1:0]           disc_wa, disc_ra;
  logic [DISC_W-1:0]       disc_wd, disc_rd;
  logic                    edge_we;
  logic [EW-1:0]           edge_wa, edge_ra;
  logic [2*VW-1:0]         edge_wd, edge_rd;

  logic [CW-1:0]     n;
  logic [VW-1:0]     vv;
  logic              done;

  bcf_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj (
    .clk, .we(adj_we), .waddr(adj_wa), .wdata(adj_wd), .raddr(adj_ra), .rdata(adj_rd));
  bcf_ram #(.WIDTH(DISC_W), .DEPTH(MAX_VERTICES)) u_disc (
    .clk, .we(disc_we), .waddr(disc_wa), .wdata(disc_wd), .raddr(disc_ra), .rdata(disc_rd));
  bcf_ram #(.WIDTH(2*VW), .DEPTH(EDGE_CAP)) u_edge (
    .clk, .we(edge_we), .waddr(edge_wa), .wdata(edge_wd), .raddr(edge_ra), .rdata(edge_rd));

  assign n    = (vcount > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : vcount;
  assign vv   = v_r[VW-1:0];
  assign fpop = fs_r[3'(depth_r - CW'(2))];
  assign done = (edge_rd == {ta_r, tb_r}) || (esc_r == '0);
  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // clearing pass over the adjacency ram after reset
      state_r <= S_CLR;
      clr_r   <= '0;
      depth_r <= '0;
      esc_r   <= '0;
      vis_r   <= '0;
      time_r  <= '0;
      comp_r  <= '0;
      root_r  <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      depth_r <= depth_nxt;
      esc_r   <= esc_nxt;
      vis_r   <= vis_nxt;
      time_r  <= time_nxt;
      comp_r  <= comp_nxt;
      root_r  <= root_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_r <= b_nxt;  u_r <= u_nxt;  up_r <= up_nxt;
    bv_r <= bv_nxt; ta_r <= ta_nxt;  tb_r <= tb_nxt; v_r <= v_nxt;
    ud_r <= ud_nxt; ul_r <= ul_nxt;  row_r <= row_nxt;
    if (fs_we) begin
      fs_r[fs_wa] <= fs_wd;
    end
  end

  always_comb begin
    state_nxt = state_r;
    b_nxt = b_r; clr_nxt = clr_r; u_nxt = u_r; up_nxt = up_r; bv_nxt = bv_r;
    ta_nxt = ta_r; tb_nxt = tb_r; v_nxt = v_r; ud_nxt = ud_r; ul_nxt = ul_r;
    row_nxt = row_r; vis_nxt = vis_r; time_nxt = time_r; comp_nxt = comp_r;
    root_nxt = root_r; depth_nxt = depth_r; esc_nxt = esc_r;
    fs_we = 1'b0; fs_wa = '0; fs_wd = '0;
    adj_we = 1'b0; adj_wa = '0; adj_wd = '0; adj_ra = '0;
    disc_we = 1'b0; disc_wa = '0; disc_wd = '0; disc_ra = vv;
    edge_we = 1'b0; edge_wa = esc_r; edge_wd = {u_r, vv}; edge_ra = esc_r;
    emit = '0;

    case (state_r)
      S_IDLE: begin
        adj_ra = in_a;
        b_nxt  = in_b;
        if (in_valid) begin
          case (in_cmd)
            CMD_ADD:   state_nxt = S_ADD_WA;
            CMD_CLEAR: begin
              clr_nxt   = '0;
              state_nxt = S_CLR;
            end
            CMD_RUN: begin
              vis_nxt = '0; time_nxt = '0; comp_nxt = '0; esc_nxt = '0;
              root_nxt = '0; depth_nxt = '0;
              state_nxt = S_ROOT;
            end
            default: state_nxt = S_IDLE;
          endcase
          u_nxt = in_a;
        end
      end
      S_ADD_WA: begin
        adj_we = 1'b1; adj_wa = u_r; adj_wd = adj_rd | (MAX_VERTICES'(1) << b_r);
        state_nxt = S_ADD_RB;
      end
      S_ADD_RB: begin
        adj_ra = b_r;
        state_nxt = S_ADD_WB;
      end
      S_ADD_WB: begin
        adj_we = 1'b1; adj_wa = b_r; adj_wd = adj_rd | (MAX_VERTICES'(1) << u_r);
        state_nxt = S_IDLE;
      end
      S_CLR: begin
        adj_we = 1'b1; adj_wa = clr_r; adj_wd = '0;
        clr_nxt = clr_r + VW'(1);
        if (clr_r == VW'(MAX_VERTICES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_ROOT: begin
        if (root_r >= n) begin
          state_nxt = S_FIN;
        end else if (vis_r[root_r[VW-1:0]]) begin
          root_nxt = root_r + CW'(1);
        end else begin
          vis_nxt[root_r[VW-1:0]] = 1'b1;
          time_nxt = time_r + DISC_W'(1);
          disc_we = 1'b1; disc_wa = root_r[VW-1:0]; disc_wd = time_nxt;
          adj_ra = root_r[VW-1:0];
          u_nxt = root_r[VW-1:0]; up_nxt = root_r[VW-1:0];
          ud_nxt = time_nxt; ul_nxt = time_nxt; v_nxt = '0;
          depth_nxt = CW'(1);
          state_nxt = S_ROW;
        end
      end
      S_ROW: begin
        row_nxt = adj_rd;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (v_r >= n) begin
          state_nxt = S_RET;
        end else begin
          v_nxt = v_r + CW'(1);
          if (row_r[vv]) begin
            if (!vis_r[vv]) begin
              // tree edge: save this frame, descend into v
              edge_we = 1'b1;
              esc_nxt = esc_r + EW'(1);
              fs_we = 1'b1; fs_wa = 3'(depth_r - CW'(1));
              fs_wd = '{u: u_r, v: v_nxt, disc: ud_r, low: ul_r, par: up_r, row: row_r};
              vis_nxt[vv] = 1'b1;
              time_nxt = time_r + DISC_W'(1);
              disc_we = 1'b1; disc_wa = vv; disc_wd = time_nxt;
              adj_ra = vv;
              u_nxt = vv; up_nxt = u_r; ud_nxt = time_nxt; ul_nxt = time_nxt;
              v_nxt = '0;
              depth_nxt = depth_r + CW'(1);
              state_nxt = S_ROW;
            end else if (vv != up_r) begin
              bv_nxt = vv;
              state_nxt = S_BACK;
            end
          end
        end
      end
      S_BACK: begin
        if (disc_rd < ud_r) begin
          if (disc_rd < ul_r) begin
            ul_nxt = disc_rd;
          end
          edge_we = 1'b1; edge_wd = {u_r, bv_r};
          esc_nxt = esc_r + EW'(1);
        end
        state_nxt = S_SCAN;
      end
      S_RET: begin
        depth_nxt = depth_r - CW'(1);
        if (depth_r == CW'(1)) begin
          root_nxt = root_r + CW'(1);
          state_nxt = S_ROOT;
        end else begin
          u_nxt = fpop.u; v_nxt = fpop.v; ud_nxt = fpop.disc; up_nxt = fpop.par;
          row_nxt = fpop.row;
          ul_nxt = (ul_r < fpop.low) ? ul_r : fpop.low;
          if (ul_r >= fpop.disc) begin
            comp_nxt = comp_r + COMP_W'(1);
            ta_nxt = fpop.u; tb_nxt = u_r;
            state_nxt = S_POP;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_POP: begin
        if (esc_r == '0) begin
          state_nxt = S_SCAN;
        end else begin
          esc_nxt = esc_r - EW'(1);
          edge_ra = esc_nxt;
          state_nxt = S_POP_D;
        end
      end
      S_POP_D: begin
        emit.vld = 1'b1;
        emit.item = '{comp: comp_r, from_v: edge_rd[2*VW-1:VW], to_v: edge_rd[VW-1:0],
                      present: 1'b1, eoc: done, last: 1'b0};
        if (emit_rdy) begin
          state_nxt = done ? S_SCAN : S_POP;
        end
      end
      S_FIN: begin
        emit.vld = 1'b1;
        emit.fin = 1'b1;
        if (emit_rdy) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `BCF_ASSERT(a_esc_cap, esc_r <= EW'(EDGE_CAP), "edge stack overflow")
  `BCF_ASSERT(a_depth_cap, depth_r <= CW'(MAX_VERTICES), "frame stack overflow")
  `BCF_ASSERT_IMP(a_root_depth, state_r == S_ROOT, depth_r == '0, "root scan with open frames")

endmodule

/* rtl/biconnected_component_finder.sv */
// channel | dir | payload                                           | handshake
// in_if   | in  | cmd, vertex_a, vertex_b                           | valid/ready
// out_if  | out | component_index, edge_from, edge_to, edge_present, | valid/ready
//         |     | end_of_component, last                            |
// cfg     | in  | vertex_count                                      | cfg_we
// add edge: two read-modify-writes of the adjacency ram; clear: one write per adjacency row.
// run: a root check per vertex below n (n = vertex count) and a closing one, then per
//   visited vertex a row fetch, a scan step per adjacency bit, a row end and a return,
//   a check per visited non-parent neighbour, a pop and an emit per edge and a final item.
// the last edge of a run is held back one item so that last can be set on it.
// reset is synchronous, active low; vertex_count is 8 and a clearing pass zeroes the graph,
//   with in_if not ready until it ends.
// a stalled out_if stops the edge pops; in_if is ready only while no command is busy.

module biconnected_component_finder import bcf_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [CW-1:0] cfg_wdata,
  bcf_in_if.sink        in_if,
  bcf_out_if.source     out_if
);

  logic [CW-1:0] vcount_r;
  emit_t         emit;
  logic          emit_rdy;
  res_t          hold_r, out_r, fin_item;
  logic          hold_v_r, out_v_r;

  bcf_ctrl u_ctrl (
    .clk, .rst_n, .vcount(vcount_r),
    .in_valid(in_if.valid), .in_ready(in_if.ready), .in_cmd(in_if.cmd),
    .in_a(in_if.vertex_a), .in_b(in_if.vertex_b),
    .emit, .emit_rdy
  );

  assign emit_rdy = !out_v_r || out_if.ready;

  // empty run gives one blank item
  always_comb begin
    fin_item      = hold_v_r ? hold_r : '0;
    fin_item.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= VCOUNT_RST;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        vcount_r <= cfg_wdata;
      end
      if (out_v_r && out_if.ready) begin
        out_v_r <= 1'b0;
      end
      if (emit.vld && emit_rdy) begin
        if (emit.fin) begin
          out_v_r  <= 1'b1;
          hold_v_r <= 1'b0;
        end else begin
          if (hold_v_r) begin
            out_v_r <= 1'b1;
          end
          hold_v_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit.vld && emit_rdy) begin
      if (emit.fin) begin
        out_r <= fin_item;
      end else begin
        out_r  <= hold_r;
        hold_r <= emit.item;
      end
    end
  end

  assign out_if.valid            = out_v_r;
  assign out_if.component_index  = out_r.comp;
  assign out_if.edge_from        = out_r.from_v;
  assign out_if.edge_to          = out_r.to_v;
  assign out_if.edge_present     = out_r.present;
  assign out_if.end_of_component = out_r.eoc;
  assign out_if.last             = out_r.last;

endmodule
